### rtl/cpph_pkg.sv
// ----------------------------------------------------------------------------
// cpph_pkg
// shared widths, command codes and ratio limits for cyclic pattern playback
// ----------------------------------------------------------------------------
`default_nettype none

package cpph_pkg;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int RATIO_W  = 27;
    localparam int CMD_W    = 2;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

    // hold ratio below this value plays one slot per sample
    localparam logic [RATIO_W-1:0] RATIO_MIN = 27'd2;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 27'd1;

endpackage

`default_nettype wire

### rtl/cyclic_pattern_playback_with_hold_top.sv
// ----------------------------------------------------------------------------
// cyclic_pattern_playback_with_hold_top
// logic pattern generator: sample store with cyclic playback and sample hold
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) takes one command word per ready cycle:
//   write appends sample_in to the store (dropped once full), commit arms
//   playback with the current hold_ratio, read asks for the next output slot
//   output channel (out_valid/out_ready) returns one word per read command:
//   the played sample, or zero with store_empty set when nothing is loaded
//   hold_ratio must be written via cfg_wr_en/cfg_wr_data while the block idles
//   (the block does not enforce this); it only takes effect at the next commit
// timing
//   a read word passes through the registered read of the sample ram and then
//   the output register before it appears at the output
//   one command word per cycle sustained while out_ready stays high; write and commit give no word
// reset
//   store count, play position, hold count and flags clear; hold_ratio is 1;
//   the sample ram is not cleared, entries are only read once written
// stalls
//   while out_ready is low the output word holds; one more read result waits
//   in the ram output stage, after which in_ready drops
// ----------------------------------------------------------------------------
`default_nettype none

module cyclic_pattern_playback_with_hold_top
    import cpph_pkg::*;
#(
    parameter int STORE_DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // configuration
    input  wire logic                cfg_wr_en,
    input  wire logic [RATIO_W-1:0]  cfg_wr_data,
    // command words
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [CMD_W-1:0]    command,
    input  wire logic [SAMPLE_W-1:0] sample_in,
    // result words
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic      [SAMPLE_W-1:0] sample_out,
    output logic                     store_empty
);

    // address width and count width (count can hold the depth itself)
    localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

    // control state
    logic [CW-1:0]      count_reg,     count_next;
    logic [AW-1:0]      pos_reg,       pos_next;
    logic [RATIO_W-1:0] hold_reg,      hold_next;
    logic               committed_reg, committed_next;
    logic               reload_reg,    reload_next;
    logic [RATIO_W-1:0] active_reg,    active_next;
    logic [RATIO_W-1:0] ratio_cfg_reg;

    // ram output stage and output register
    logic               s1_valid_reg;
    logic               s1_empty_reg;
    logic               out_valid_reg;
    logic [SAMPLE_W-1:0] sample_out_reg;
    logic               store_empty_reg;

    // ram ports
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [SAMPLE_W-1:0] ram_rdata;

    // working values
    logic                accept;
    logic                s1_move;
    logic                is_read;
    logic                rd_empty;
    logic [CW-1:0]       base_count;
    logic [AW-1:0]       cur_pos;
    logic [CW-1:0]       nxt_pos;
    logic [RATIO_W:0]    hold_inc;
    logic [RATIO_W-1:0]  ratio;

    // output stage frees when empty or being taken; ram stage frees likewise
    assign s1_move  = !out_valid_reg || out_ready;
    assign in_ready = !s1_valid_reg || s1_move;
    assign accept   = in_valid && in_ready;

    // command decode and state update
    always_comb
    begin
        count_next     = count_reg;
        pos_next       = pos_reg;
        hold_next      = hold_reg;
        committed_next = committed_reg;
        reload_next    = reload_reg;
        active_next    = active_reg;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        is_read        = 1'b0;
        rd_empty       = (count_reg == '0);
        base_count     = reload_reg ? '0 : count_reg;
        ram_waddr      = base_count[AW-1:0];
        cur_pos        = ({1'b0, pos_reg} >= count_reg) ? '0 : pos_reg;
        ram_raddr      = cur_pos;
        nxt_pos        = {1'b0, cur_pos} + CW'(1);
        hold_inc       = {1'b0, hold_reg} + (RATIO_W+1)'(1);
        ratio          = committed_reg ? active_reg : RATIO_ONE;

        if (accept)
        begin
            unique case (command)
                CMD_WRITE:
                begin
                    // first write after a commit starts a new load
                    if (reload_reg)
                    begin
                        pos_next       = '0;
                        hold_next      = '0;
                        committed_next = 1'b0;
                        reload_next    = 1'b0;
                    end
                    count_next = base_count;
                    if (base_count != DEPTH_C)
                    begin
                        ram_we     = 1'b1;
                        count_next = base_count + CW'(1);
                    end
                end
                CMD_COMMIT:
                begin
                    active_next    = (ratio_cfg_reg < RATIO_MIN) ? RATIO_ONE : ratio_cfg_reg;
                    committed_next = 1'b1;
                    reload_next    = 1'b1;
                    pos_next       = '0;
                    hold_next      = '0;
                end
                CMD_READ:
                begin
                    is_read = 1'b1;
                    if (!rd_empty)
                    begin
                        ram_re = 1'b1;
                        if (hold_inc >= {1'b0, ratio})
                        begin
                            // move on to the next sample, wrapping at the end
                            hold_next = '0;
                            pos_next  = (nxt_pos >= count_reg) ? '0 : nxt_pos[AW-1:0];
                        end
                        else
                        begin
                            hold_next = hold_inc[RATIO_W-1:0];
                            pos_next  = cur_pos;
                        end
                    end
                end
                default:
                begin
                    // unused code: no effect, no result
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            pos_reg       <= '0;
            hold_reg      <= '0;
            committed_reg <= 1'b0;
            reload_reg    <= 1'b0;
            active_reg    <= RATIO_ONE;
            ratio_cfg_reg <= RATIO_ONE;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            hold_reg      <= hold_next;
            committed_reg <= committed_next;
            reload_reg    <= reload_next;
            active_reg    <= active_next;
            if (cfg_wr_en)
            begin
                ratio_cfg_reg <= cfg_wr_data;
            end
            if (in_ready)
            begin
                s1_valid_reg <= accept && is_read;
            end
            if (s1_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ready)
        begin
            s1_empty_reg <= rd_empty;
        end
        if (s1_move && s1_valid_reg)
        begin
            sample_out_reg  <= s1_empty_reg ? '0 : ram_rdata;
            store_empty_reg <= s1_empty_reg;
        end
    end

    cpph_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sample_in),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid   = out_valid_reg;
    assign sample_out  = sample_out_reg;
    assign store_empty = store_empty_reg;

endmodule

`default_nettype wire

### rtl/cpph_ram.sv
// ----------------------------------------------------------------------------
// cpph_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module cpph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        // read data holds while no read is issued
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
